### hw/rtl/bde_pkg.sv
// Shared types, codes and constants of the button digit entry editor.
package bde_pkg;

	localparam int WORD_W     = 32;
	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = 4;
	localparam int COUNT_W    = 4;
	localparam int LIMIT_W    = 16;
	localparam int IDLE_W     = 17;
	localparam int CURSOR_W   = 3;
	localparam int BUTTON_W   = 3;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int DIV_STEPS  = 8;
	localparam int DIV_CHUNKS = WORD_W / DIV_STEPS;

	localparam logic [RADIX_W-1:0] RADIX_RST       = 5'd10;
	localparam logic [COUNT_W-1:0] DIGIT_COUNT_RST = 4'd4;
	localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST  = 16'd5000;
	localparam logic [WORD_W-1:0]  START_VALUE_RST = 32'd0;
	localparam logic [IDLE_W-1:0]  IDLE_SAT        = 17'h1FFFF;
	localparam logic [RADIX_W-1:0] RADIX_MIN       = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX       = 5'd16;

	localparam logic [0:0] OP_POLL  = 1'b0;
	localparam logic [0:0] OP_START = 1'b1;

	localparam logic [BUTTON_W-1:0] KEY_NONE   = 3'd0;
	localparam logic [BUTTON_W-1:0] KEY_SELECT = 3'd1;
	localparam logic [BUTTON_W-1:0] KEY_LEFT   = 3'd2;
	localparam logic [BUTTON_W-1:0] KEY_RIGHT  = 3'd3;
	localparam logic [BUTTON_W-1:0] KEY_UP     = 3'd4;
	localparam logic [BUTTON_W-1:0] KEY_DOWN   = 3'd5;

	localparam logic [STATUS_W-1:0] ST_EDIT    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SELECT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 2'd3;

	typedef enum logic [0:0] {
		ALU_DIV,
		ALU_MAC
	} alu_op_t;

	typedef struct packed {
		alu_op_t              op;
		logic [RADIX_W-1:0]   radix;
		logic [WORD_W-1:0]    word;
		logic [RADIX_W-1:0]   rem;
		logic [DIGIT_W-1:0]   digit;
	} alu_req_t;

	typedef struct packed {
		logic [WORD_W-1:0]    word;
		logic [RADIX_W-1:0]   rem;
	} alu_rsp_t;

endpackage

### hw/rtl/bde_if.sv
// Valid/ready channel interfaces for the editor's input items and results.
interface bde_item_if;
	logic                          valid;
	logic                          ready;
	logic [0:0]                    opcode;
	logic [bde_pkg::BUTTON_W-1:0]  button;

	modport source (output valid, output opcode, output button, input ready);
	modport sink (input valid, input opcode, input button, output ready);
endinterface

interface bde_result_if;
	logic                          valid;
	logic                          ready;
	logic [bde_pkg::STATUS_W-1:0]  status;
	logic [bde_pkg::CURSOR_W-1:0]  cursor_position;
	logic [bde_pkg::WORD_W-1:0]    entered_value;

	modport source (output valid, output status, output cursor_position,
		output entered_value, input ready);
	modport sink (input valid, input status, input cursor_position,
		input entered_value, output ready);
endinterface

### hw/rtl/bde_alu.sv
// Shared arithmetic unit: eight restoring division steps or one multiply-accumulate.
module bde_alu (
	input  bde_pkg::alu_req_t req,
	output bde_pkg::alu_rsp_t rsp
);

	always_comb begin
		logic [bde_pkg::WORD_W-1:0]  w;
		logic [bde_pkg::RADIX_W:0]   t;
		logic [bde_pkg::RADIX_W-1:0] rm;
		w  = req.word;
		rm = req.rem;
		rsp = '0;
		unique case (req.op)
			bde_pkg::ALU_DIV: begin
				// Quotient bits shift in at the bottom as dividend bits leave the top.
				for (int k = 0; k < bde_pkg::DIV_STEPS; k++) begin
					t = {rm, w[bde_pkg::WORD_W-1]};
					w = {w[bde_pkg::WORD_W-2:0], 1'b0};
					if (t >= {1'b0, req.radix}) begin
						t = t - {1'b0, req.radix};
						w[0] = 1'b1;
					end
					rm = t[bde_pkg::RADIX_W-1:0];
				end
				rsp.word = w;
				rsp.rem  = rm;
			end
			bde_pkg::ALU_MAC: begin
				rsp.word = req.word * bde_pkg::WORD_W'(req.radix)
					+ bde_pkg::WORD_W'(req.digit);
				rsp.rem  = '0;
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

endmodule

### hw/rtl/button_digit_entry_editor_core.sv
// Top level of the button digit entry editor: registers, digit store and sequencer.
//
// Usage. Input items arrive on the item channel (opcode, button) and each one
// yields exactly one result beat on the result channel (status,
// cursor_position, entered_value). Opcode start loads the digits from the
// start_value register in the configured radix; opcode poll is one time tick
// carrying the current button. Registers are written through cfg_wr_en,
// cfg_index and cfg_data by the user only while the block is idle; the block does not enforce this.
// Sequence. A poll edits the state in its accept cycle, then copies the digits
// and runs one multiply-accumulate per digit in use, at most MAX_DIGITS of them.
// A start first runs the shared unit as a divider, eight quotient bits a cycle,
// taking one digit off per full division of the word by the radix, then runs
// the same copy and value pass. One item is worked on at a time.
// Stalls. The result sits in an output register, so the next item can be
// accepted while a result still waits; the sequencer then holds its finished
// value until the receiver takes the waiting beat.
// Reset. arst_n clears the registers to their defaults (radix 10, four digits,
// idle limit 5000, start value 0), all digits, the cursor, the previous button
// and the idle timer.
module button_digit_entry_editor_core #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [bde_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bde_pkg::WORD_W-1:0]      cfg_data,
	bde_item_if.sink                        item,
	bde_result_if.source                    result
);

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam logic [bde_pkg::COUNT_W-1:0] MAX_N = bde_pkg::COUNT_W'(MAX_DIGITS);
	localparam logic [1:0] LAST_CHUNK = 2'(bde_pkg::DIV_CHUNKS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_LOAD,
		S_MAC,
		S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [bde_pkg::RADIX_W-1:0] radix_q;
	logic [bde_pkg::COUNT_W-1:0] digit_count_q;
	logic [bde_pkg::LIMIT_W-1:0] idle_limit_q;
	logic [bde_pkg::WORD_W-1:0]  start_value_q;

	// Editor state.
	logic [bde_pkg::DIGIT_W-1:0]  digit_store_q [MAX_DIGITS];
	logic [bde_pkg::CURSOR_W-1:0] cursor_q;
	logic [bde_pkg::BUTTON_W-1:0] prev_button_q;
	logic [bde_pkg::IDLE_W-1:0]   idle_ticks_q;

	// Sequencer working registers.
	logic [bde_pkg::DIGIT_W-1:0]  mac_sr_q [MAX_DIGITS];
	logic [bde_pkg::WORD_W-1:0]   work_q;
	logic [bde_pkg::RADIX_W-1:0]  rem_q;
	logic [1:0]                   chunk_q;
	logic [bde_pkg::COUNT_W-1:0]  dig_idx_q;
	logic [bde_pkg::COUNT_W-1:0]  mac_cnt_q;
	logic [bde_pkg::STATUS_W-1:0] status_q;

	// Output register.
	logic                         out_valid_q;
	logic [bde_pkg::STATUS_W-1:0] out_status_q;
	logic [bde_pkg::CURSOR_W-1:0] out_cursor_q;
	logic [bde_pkg::WORD_W-1:0]   out_value_q;

	bde_pkg::alu_req_t alu_req;
	bde_pkg::alu_rsp_t alu_rsp;

	// Out-of-range register values are clamped into their legal ranges.
	logic [bde_pkg::RADIX_W-1:0] eff_radix;
	logic [bde_pkg::COUNT_W-1:0] eff_len;
	logic [bde_pkg::COUNT_W-1:0] len_m1;
	logic [bde_pkg::RADIX_W-1:0] radix_m1;

	always_comb begin
		if (radix_q < bde_pkg::RADIX_MIN) begin
			eff_radix = bde_pkg::RADIX_MIN;
		end else if (radix_q > bde_pkg::RADIX_MAX) begin
			eff_radix = bde_pkg::RADIX_MAX;
		end else begin
			eff_radix = radix_q;
		end
		if (digit_count_q == '0) begin
			eff_len = bde_pkg::COUNT_W'(1);
		end else if (digit_count_q > MAX_N) begin
			eff_len = MAX_N;
		end else begin
			eff_len = digit_count_q;
		end
		len_m1   = eff_len - bde_pkg::COUNT_W'(1);
		radix_m1 = eff_radix - bde_pkg::RADIX_W'(1);
	end

	logic accept;
	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;

	// The finished result moves into the output register once that register is free
	// or its beat is being taken in the same cycle.
	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || result.ready);

	// Poll edit: the idle timer counts first; a timeout freezes everything else.
	logic [bde_pkg::IDLE_W-1:0]   idle_inc;
	logic                         timed_out;
	logic                         changed;
	logic [bde_pkg::CURSOR_W-1:0] cursor_nxt;
	logic [bde_pkg::DIGIT_W-1:0]  cur_digit;
	logic [bde_pkg::DIGIT_W-1:0]  digit_nxt;
	logic                         digit_wr;
	logic [bde_pkg::STATUS_W-1:0] poll_status;

	always_comb begin
		idle_inc    = (idle_ticks_q < bde_pkg::IDLE_SAT)
			? idle_ticks_q + bde_pkg::IDLE_W'(1) : idle_ticks_q;
		timed_out   = idle_inc > bde_pkg::IDLE_W'(idle_limit_q);
		changed     = !timed_out && (item.button != prev_button_q);
		cursor_nxt  = cursor_q;
		cur_digit   = digit_store_q[cursor_q[IDX_W-1:0]];
		digit_nxt   = cur_digit;
		digit_wr    = 1'b0;
		poll_status = timed_out ? bde_pkg::ST_TIMEOUT : bde_pkg::ST_EDIT;
		if (changed) begin
			case (item.button)
				bde_pkg::KEY_SELECT: begin
					poll_status = bde_pkg::ST_SELECT;
				end
				bde_pkg::KEY_LEFT: begin
					cursor_nxt = (cursor_q == '0)
						? len_m1[bde_pkg::CURSOR_W-1:0]
						: cursor_q - bde_pkg::CURSOR_W'(1);
				end
				bde_pkg::KEY_RIGHT: begin
					cursor_nxt = ({1'b0, cursor_q} >= len_m1)
						? '0 : cursor_q + bde_pkg::CURSOR_W'(1);
				end
				bde_pkg::KEY_UP: begin
					digit_wr  = ({1'b0, cursor_q} < MAX_N);
					digit_nxt = ({1'b0, cur_digit} == radix_m1)
						? '0 : cur_digit + bde_pkg::DIGIT_W'(1);
				end
				bde_pkg::KEY_DOWN: begin
					digit_wr  = ({1'b0, cursor_q} < MAX_N);
					digit_nxt = (cur_digit == '0)
						? radix_m1[bde_pkg::DIGIT_W-1:0]
						: cur_digit - bde_pkg::DIGIT_W'(1);
				end
				default: begin
					// No button and the unused codes only clear the timer and become the previous button.
				end
			endcase
		end
	end

	// The shared unit divides while loading digits and accumulates otherwise.
	always_comb begin
		alu_req.op    = (state_q == S_DIV) ? bde_pkg::ALU_DIV : bde_pkg::ALU_MAC;
		alu_req.radix = eff_radix;
		alu_req.word  = work_q;
		alu_req.rem   = rem_q;
		alu_req.digit = mac_sr_q[0];
	end

	bde_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			radix_q       <= bde_pkg::RADIX_RST;
			digit_count_q <= bde_pkg::DIGIT_COUNT_RST;
			idle_limit_q  <= bde_pkg::IDLE_LIMIT_RST;
			start_value_q <= bde_pkg::START_VALUE_RST;
			for (int k = 0; k < MAX_DIGITS; k++) begin
				digit_store_q[k] <= '0;
				mac_sr_q[k]      <= '0;
			end
			cursor_q      <= '0;
			prev_button_q <= bde_pkg::KEY_NONE;
			idle_ticks_q  <= '0;
			work_q        <= '0;
			rem_q         <= '0;
			chunk_q       <= '0;
			dig_idx_q     <= '0;
			mac_cnt_q     <= '0;
			status_q      <= bde_pkg::ST_EDIT;
			out_valid_q   <= 1'b0;
			out_status_q  <= bde_pkg::ST_EDIT;
			out_cursor_q  <= '0;
			out_value_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					bde_pkg::CFG_RADIX:       radix_q <= cfg_data[bde_pkg::RADIX_W-1:0];
					bde_pkg::CFG_DIGIT_COUNT: digit_count_q <= cfg_data[bde_pkg::COUNT_W-1:0];
					bde_pkg::CFG_IDLE_LIMIT:  idle_limit_q <= cfg_data[bde_pkg::LIMIT_W-1:0];
					bde_pkg::CFG_START_VALUE: start_value_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.opcode == bde_pkg::OP_START) begin
							for (int k = 0; k < MAX_DIGITS; k++) begin
								digit_store_q[k] <= '0;
							end
							cursor_q      <= len_m1[bde_pkg::CURSOR_W-1:0];
							prev_button_q <= item.button;
							idle_ticks_q  <= '0;
							status_q      <= bde_pkg::ST_EDIT;
							work_q        <= start_value_q;
							rem_q         <= '0;
							chunk_q       <= '0;
							dig_idx_q     <= len_m1;
							state_q       <= S_DIV;
						end else begin
							status_q <= poll_status;
							cursor_q <= cursor_nxt;
							if (changed) begin
								prev_button_q <= item.button;
								idle_ticks_q  <= '0;
							end else begin
								idle_ticks_q <= idle_inc;
							end
							if (digit_wr) begin
								digit_store_q[cursor_q[IDX_W-1:0]] <= digit_nxt;
							end
							state_q <= S_LOAD;
						end
					end
				end
				S_DIV: begin
					// Least significant digit first, written from the last index down.
					work_q  <= alu_rsp.word;
					chunk_q <= chunk_q + 2'd1;
					if (chunk_q == LAST_CHUNK) begin
						digit_store_q[dig_idx_q[IDX_W-1:0]] <=
							alu_rsp.rem[bde_pkg::DIGIT_W-1:0];
						rem_q <= '0;
						if (dig_idx_q == '0) begin
							state_q <= S_LOAD;
						end else begin
							dig_idx_q <= dig_idx_q - bde_pkg::COUNT_W'(1);
						end
					end else begin
						rem_q <= alu_rsp.rem;
					end
				end
				S_LOAD: begin
					for (int k = 0; k < MAX_DIGITS; k++) begin
						mac_sr_q[k] <= digit_store_q[k];
					end
					work_q    <= '0;
					mac_cnt_q <= eff_len;
					state_q   <= S_MAC;
				end
				S_MAC: begin
					// Most significant digit leaves the bottom of the copy each cycle.
					work_q <= alu_rsp.word;
					for (int k = 0; k < MAX_DIGITS - 1; k++) begin
						mac_sr_q[k] <= mac_sr_q[k+1];
					end
					mac_sr_q[MAX_DIGITS-1] <= '0;
					mac_cnt_q <= mac_cnt_q - bde_pkg::COUNT_W'(1);
					if (mac_cnt_q == bde_pkg::COUNT_W'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_status_q <= status_q;
						out_cursor_q <= cursor_q;
						out_value_q  <= work_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid           = out_valid_q;
	assign result.status          = out_status_q;
	assign result.cursor_position = out_cursor_q;
	assign result.entered_value   = out_value_q;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the button digit entry editor core.
`timescale 1ns / 1ps

module tb_top;
	import bde_pkg::*;

	localparam int MAX_DIGITS   = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 50;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS  = 100;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [0:0]          opcode;
		logic [BUTTON_W-1:0] button;
	} edit_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CURSOR_W-1:0] cursor_position;
		logic [WORD_W-1:0]   entered_value;
	} edit_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	bde_item_if   item_ch ();
	bde_result_if result_ch ();

	button_digit_entry_editor_core #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	// Items waiting to be offered, and the results that the accepted items must produce,
	// oldest first.
	edit_item_t   pending_items[$];
	edit_result_t expected_results[$];

	// The testbench's own copy of the configuration registers, updated at the write edge.
	logic [RADIX_W-1:0] reg_radix       = RADIX_RST;
	logic [COUNT_W-1:0] reg_digit_count = DIGIT_COUNT_RST;
	logic [LIMIT_W-1:0] reg_idle_limit  = IDLE_LIMIT_RST;
	logic [WORD_W-1:0]  reg_start_value = START_VALUE_RST;

	// The editor state as the predictor sees it; these are the reset values.
	logic [DIGIT_W-1:0]  ed_digits [MAX_DIGITS] = '{default: '0};
	logic [CURSOR_W-1:0] ed_cursor       = '0;
	logic [BUTTON_W-1:0] ed_prev_button  = KEY_NONE;
	logic [IDLE_W-1:0]   ed_idle_ticks   = '0;

	// When idle_on is low both sides run without gaps. The sequencer raises hold_requests
	// to ask the result side for one long hold-off.
	bit          idle_on       = 1'b1;
	int unsigned hold_requests = 0;
	int unsigned holds_served  = 0;

	int unsigned fail_count      = 0;
	int unsigned items_accepted  = 0;
	int unsigned starts_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned selects_seen    = 0;
	int unsigned timeouts_seen   = 0;
	int unsigned regs_written    = 0;
	int unsigned stall_cycles    = 0;

	int send_gap;
	int recv_gap;
	int hold_left;

	// Clock: 20 ns period.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Counts a failure and prints the first few of them.
	function automatic void log_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX) begin
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	// Advances the editor by one accepted item and returns the result it must produce.
	// Out-of-range radix and digit count values are clamped first, exactly as the block
	// clamps them: a radix below two acts as two, above sixteen as sixteen; a digit count
	// of zero acts as one, above the maximum as the maximum.
	function automatic edit_result_t edit_step(input edit_item_t it);
		edit_result_t       res;
		logic [RADIX_W-1:0] r;
		logic [COUNT_W-1:0] n;
		logic [WORD_W-1:0]  v;
		logic [WORD_W-1:0]  acc;
		logic [DIGIT_W-1:0] d;
		int                 i;

		r = (reg_radix < RADIX_MIN) ? RADIX_MIN : (reg_radix > RADIX_MAX) ? RADIX_MAX : reg_radix;
		n = (reg_digit_count == 0) ? COUNT_W'(1) :
			(reg_digit_count > MAX_DIGITS) ? COUNT_W'(MAX_DIGITS) : reg_digit_count;
		res.status = ST_EDIT;

		if (it.opcode == OP_START) begin
			// Split the start value into digits, least significant last. Digits beyond
			// the count in use are cleared, and high digits that do not fit are lost.
			v = reg_start_value;
			for (i = 0; i < MAX_DIGITS; i++) begin
				ed_digits[i] = '0;
			end
			for (i = int'(n) - 1; i >= 0; i--) begin
				ed_digits[i] = DIGIT_W'(v % r);
				v = v / r;
			end
			ed_cursor      = CURSOR_W'(n - 1);
			ed_prev_button = it.button;
			ed_idle_ticks  = '0;
		end else begin
			// A poll is one tick. The timer saturates, so once it passes the limit the
			// timeout holds until the next start, unless the limit is raised meanwhile.
			if (ed_idle_ticks < IDLE_SAT) begin
				ed_idle_ticks = ed_idle_ticks + 1'b1;
			end
			if (ed_idle_ticks > reg_idle_limit) begin
				res.status = ST_TIMEOUT;
			end else if (it.button != ed_prev_button) begin
				ed_prev_button = it.button;
				ed_idle_ticks  = '0;
				// Codes six and seven only count as a change of button.
				case (it.button)
					KEY_SELECT: begin
						res.status = ST_SELECT;
					end
					KEY_LEFT: begin
						ed_cursor = (ed_cursor == 0) ? CURSOR_W'(n - 1) : ed_cursor - 1'b1;
					end
					KEY_RIGHT: begin
						// A cursor left beyond a lowered digit count wraps to zero here.
						ed_cursor = (32'(ed_cursor) >= 32'(n) - 1) ? '0 : ed_cursor + 1'b1;
					end
					KEY_UP, KEY_DOWN: begin
						// A digit at or above a lowered radix steps by one, wrapping
						// within the digit width on the way up.
						d = ed_digits[ed_cursor];
						if (it.button == KEY_UP) begin
							d = (32'(d) == 32'(r) - 1) ? '0 : d + 1'b1;
						end else begin
							d = (d == 0) ? DIGIT_W'(r - 1) : d - 1'b1;
						end
						ed_digits[ed_cursor] = d;
					end
					default: begin
					end
				endcase
			end
		end

		// Value of the digits in use, multiply-accumulate wrapping in 32 bits.
		acc = '0;
		for (i = 0; i < int'(n); i++) begin
			acc = acc * r + WORD_W'(ed_digits[i]);
		end
		res.cursor_position = ed_cursor;
		res.entered_value   = acc;
		return res;
	endfunction

	// Item driver. The head of pending_items is offered; at an accepting edge it is
	// popped and predicted, and the gap before the next item is drawn. The offer only
	// changes when the channel is free, so valid and payload hold while ready is low.
	always @(posedge clk or negedge arst_n) begin : drive_items
		edit_item_t it;
		bit         slot_free;

		if (!arst_n) begin
			item_ch.valid  <= 1'b0;
			item_ch.opcode <= OP_POLL;
			item_ch.button <= KEY_NONE;
			send_gap = 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				it = pending_items.pop_front();
				expected_results.push_back(edit_step(it));
				items_accepted++;
				if (it.opcode == OP_START) begin
					starts_accepted++;
				end
				send_gap = idle_on ? int'($urandom_range(0, 6)) : 0;
			end
			slot_free = !(item_ch.valid && !item_ch.ready);
			if (slot_free) begin
				if (send_gap > 0) begin
					send_gap--;
					item_ch.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					item_ch.valid  <= 1'b1;
					item_ch.opcode <= pending_items[0].opcode;
					item_ch.button <= pending_items[0].button;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Each beat is checked against the oldest expectation. After a beat
	// ready drops for a random number of cycles; a hold-off request keeps it low for a
	// long stretch so the block fills up and stops taking items.
	always @(posedge clk or negedge arst_n) begin : check_results
		edit_result_t want;
		edit_result_t got;

		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			recv_gap  = 0;
			hold_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got.status          = result_ch.status;
				got.cursor_position = result_ch.cursor_position;
				got.entered_value   = result_ch.entered_value;
				results_checked++;
				if (got.status == ST_SELECT) begin
					selects_seen++;
				end
				if (got.status == ST_TIMEOUT) begin
					timeouts_seen++;
				end
				if (expected_results.size() == 0) begin
					log_failure($sformatf("result beat with nothing expected: status %0d cursor %0d value 0x%08h",
						got.status, got.cursor_position, got.entered_value));
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status ||
						got.cursor_position !== want.cursor_position ||
						got.entered_value !== want.entered_value) begin
						log_failure($sformatf(
							"result %0d mismatch: status %0d/%0d cursor %0d/%0d value 0x%08h/0x%08h (expected/actual)",
							results_checked, want.status, got.status, want.cursor_position,
							got.cursor_position, want.entered_value, got.entered_value));
					end
				end
				recv_gap = idle_on ? int'($urandom_range(0, 6)) : 0;
			end
			if (holds_served < hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: counts cycles with work outstanding in which no beat moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				stall_cycles = 0;
			end else if (pending_items.size() > 0 || expected_results.size() > 0) begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("%0t: no beat for %0d cycles, %0d items pending, %0d results expected",
						$realtime, stall_cycles, pending_items.size(), expected_results.size());
					$display("[button_digit_entry_editor_core] ERROR");
					$finish;
				end
			end
		end
	end

	function automatic void push_item(input logic [0:0] op, input logic [BUTTON_W-1:0] btn);
		edit_item_t it;

		it.opcode = op;
		it.button = btn;
		pending_items.push_back(it);
	endfunction

	// Register write: one cycle with the write enable high. The copy used for prediction
	// changes at the same edge; the block is idle whenever this is called.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_RADIX:       reg_radix       = data[RADIX_W-1:0];
			CFG_DIGIT_COUNT: reg_digit_count = data[COUNT_W-1:0];
			CFG_IDLE_LIMIT:  reg_idle_limit  = data[LIMIT_W-1:0];
			CFG_START_VALUE: reg_start_value = data;
			default: begin
			end
		endcase
		regs_written++;
	endtask

	// Waits until every item is accepted and every result has come back, then a short
	// pause, and returns at a falling edge.
	task automatic settle();
		@(negedge clk);
		while (pending_items.size() > 0 || expected_results.size() > 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	initial begin : sequencer
		logic [BUTTON_W-1:0] held;
		int                  phase;
		int                  k;
		int                  pick;

		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_RADIX;
		cfg_data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset configuration (radix ten, four digits). Polls before any
		// start work on the cleared state; codes six and seven only reset the timer;
		// a repeated select is plain processing.
		push_item(OP_POLL, KEY_NONE);
		push_item(OP_POLL, KEY_UP);
		push_item(OP_POLL, KEY_DOWN);
		push_item(OP_POLL, KEY_LEFT);
		push_item(OP_POLL, KEY_RIGHT);
		push_item(OP_POLL, 3'd6);
		push_item(OP_POLL, 3'd7);
		push_item(OP_POLL, KEY_SELECT);
		push_item(OP_POLL, KEY_SELECT);
		push_item(OP_START, KEY_UP);
		push_item(OP_POLL, KEY_UP);
		settle();

		// Widest setting with all digits at the top of the radix, then a tight idle limit
		// so that a held button runs into the timeout and a change does not lift it.
		write_reg(CFG_RADIX, 32'd16);
		write_reg(CFG_DIGIT_COUNT, 32'd8);
		write_reg(CFG_IDLE_LIMIT, 32'd2);
		write_reg(CFG_START_VALUE, 32'hFFFF_FFFF);
		@(negedge clk);
		push_item(OP_START, KEY_NONE);
		push_item(OP_POLL, KEY_UP);
		push_item(OP_POLL, KEY_UP);
		push_item(OP_POLL, KEY_UP);
		push_item(OP_POLL, KEY_UP);
		push_item(OP_POLL, KEY_DOWN);
		settle();

		// Mid-session change: radix below range and digit count zero, with the cursor
		// left beyond the digits in use and digits above the new radix. Raising the limit
		// lets the timed-out session resume.
		write_reg(CFG_RADIX, 32'd0);
		write_reg(CFG_DIGIT_COUNT, 32'd0);
		write_reg(CFG_IDLE_LIMIT, 32'd65535);
		@(negedge clk);
		push_item(OP_POLL, KEY_UP);
		push_item(OP_POLL, KEY_RIGHT);
		push_item(OP_POLL, KEY_LEFT);
		settle();

		// Radix and digit count above range, a start value that fills every digit, and an
		// idle limit of zero, where the first tick after a start already times out.
		write_reg(CFG_RADIX, 32'd31);
		write_reg(CFG_DIGIT_COUNT, 32'd15);
		write_reg(CFG_START_VALUE, 32'hDEAD_BEEF);
		@(negedge clk);
		push_item(OP_START, KEY_SELECT);
		push_item(OP_POLL, KEY_SELECT);
		push_item(OP_POLL, KEY_NONE);
		settle();
		write_reg(CFG_IDLE_LIMIT, 32'd0);
		@(negedge clk);
		push_item(OP_POLL, KEY_DOWN);
		settle();

		// Random part. Each phase draws a new setting, mostly in range, with junk in the
		// unused upper bits of the write data. Most phases open with a start; the rest
		// keep the old session under the new setting. Buttons are often held so the idle
		// timer runs, and small limits make timeouts common.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			pick = $urandom_range(0, 99);
			write_reg(CFG_RADIX, 32'({$urandom, 5'b0}) |
				((pick < 85) ? 32'($urandom_range(2, 16)) : 32'($urandom_range(0, 31))));
			pick = $urandom_range(0, 99);
			write_reg(CFG_DIGIT_COUNT, 32'({$urandom, 4'b0}) |
				((pick < 85) ? 32'($urandom_range(1, 8)) : 32'($urandom_range(0, 15))));
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				write_reg(CFG_IDLE_LIMIT, 32'({$urandom, 16'b0}) | 32'($urandom_range(1, 12)));
			end else if (pick < 80) begin
				write_reg(CFG_IDLE_LIMIT, $urandom);
			end else if (pick < 90) begin
				write_reg(CFG_IDLE_LIMIT, 32'({$urandom, 16'b0}));
			end else begin
				write_reg(CFG_IDLE_LIMIT, 32'({$urandom, 16'hFFFF}));
			end
			pick = $urandom_range(0, 9);
			write_reg(CFG_START_VALUE, (pick == 0) ? 32'd0 :
				(pick == 1) ? 32'hFFFF_FFFF : 32'($urandom));
			@(negedge clk);

			// One phase in four runs without any idling; phase three also asks for a long
			// hold-off on the result side while items keep coming.
			idle_on = (phase % 4 != 1);
			if (phase == 3) begin
				hold_requests++;
			end

			held = KEY_NONE;
			if ($urandom_range(0, 4) != 0) begin
				held = BUTTON_W'($urandom_range(0, 5));
				push_item(OP_START, held);
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 6) begin
					held = BUTTON_W'($urandom_range(0, 7));
					push_item(OP_START, held);
				end else if (pick < 45) begin
					push_item(OP_POLL, held);
				end else if (pick < 95) begin
					held = BUTTON_W'($urandom_range(0, 5));
					push_item(OP_POLL, held);
				end else begin
					held = BUTTON_W'($urandom_range(6, 7));
					push_item(OP_POLL, held);
				end
			end
			settle();
		end

		// Let any late or stray beat show up before the verdict.
		idle_on = 1'b1;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			log_failure($sformatf("%0d results never arrived", expected_results.size()));
		end

		$display("Run covered %0d items (%0d starts) and %0d result beats over %0d register writes.",
			items_accepted, starts_accepted, results_checked, regs_written);
		$display("Results included %0d selects and %0d timeouts; %0d failures found.",
			selects_seen, timeouts_seen, fail_count);
		if (fail_count == 0) begin
			$display("[button_digit_entry_editor_core] OK");
		end else begin
			$display("[button_digit_entry_editor_core] ERROR");
		end
		$finish;
	end

endmodule
